FILE: sv/pprle_pkg.sv
// shared types and constants for the packed pixel run-length encoder
// no dependencies
package pprle_pkg;

    localparam int MAP_ENTRIES = 256;
    localparam int WORD_BITS   = 32;
    localparam int MAP_AW      = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int PIX_CNT_W   = $clog2(WORD_BITS + 1);

    localparam logic [2:0] REG_PIXEL_DEPTH  = 3'd0;
    localparam logic [2:0] REG_NATIVE_DEPTH = 3'd1;
    localparam logic [2:0] REG_PACK_RUNS    = 3'd2;
    localparam logic [2:0] REG_COLOR_COUNT  = 3'd3;
    localparam logic [2:0] REG_COLOR_BYTES  = 3'd4;
    localparam logic [2:0] REG_BYTE_BUDGET  = 3'd5;

    localparam logic [7:0]  PACKED_FLAG = 8'h80;
    localparam logic [16:0] BYTES_MAX   = 17'h1FFFF;

    // one finished run on its way to the map lookup
    typedef struct packed {
        logic [7:0]  color;
        logic [15:0] len;
        logic        last;
    } run_req_t;

endpackage

FILE: sv/pprle_map.sv
// color map memory: one write port, one registered read port
// depends on pprle_pkg
module pprle_map
    import pprle_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [MAP_AW-1:0] wr_addr,
    input  logic [6:0]        wr_data,
    input  logic              rd_en,
    input  logic [MAP_AW-1:0] rd_addr,
    output logic [6:0]        rd_data
);
    logic [6:0] mem [MAP_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

FILE: sv/packed_pixel_run_length_encoder.sv
// top level of the packed pixel run-length encoder
// depends on pprle_pkg and pprle_map
// A pixel word is accepted only while idle; the scanner then takes one pixel
// per cycle (32, 16, 8 or 4 at 1, 2, 4 or 8 bits per pixel, half that for a
// half-valid word), pausing for each emitted run to pass the color map's
// registered read (lookup, then account). The word is then closed and checked
// for the end of the tile. A word of an aborted tile is not scanned. Map writes
// are taken while idle. Runs leave through a one-entry output register; a run
// waits in accounting while a full output register is not drained.
module packed_pixel_run_length_encoder
    import pprle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: pixel_word[31:0], half_valid[32], map_index[40:33], map_value[47:41]
    input  logic [47:0] s_tdata,
    // tuser: mode
    input  logic        s_tuser,
    // tlast: last_word
    input  logic        s_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: color_code[7:0], run_minus_one[23:8], single_byte[24],
    //        runs_of_one[40:25], overflow[41], zero pad [47:42]
    output logic [47:0] m_tdata,
    // tlast: last_run
    output logic        m_tlast
);
    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LOOK, S_ACCT, S_END} state_t;

    logic [1:0]  pix_depth_reg, nat_depth_reg;
    logic        pack_reg;
    logic [8:0]  ccount_reg;
    logic [2:0]  cbytes_reg;
    logic [15:0] budget_reg;

    state_t      state_reg;
    logic [31:0] word_reg;
    logic [PIX_CNT_W-1:0] left_reg;
    logic        lastw_reg, first_reg, started_reg, aborted_reg;
    logic [7:0]  run_color_reg;
    logic [15:0] run_len_reg, singles_reg;
    logic [16:0] bytes_reg;
    run_req_t    pend_reg;
    logic        out_v_reg;
    logic [47:0] out_d_reg;
    logic        out_l_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_v_reg;
    assign m_tdata   = out_d_reg;
    assign m_tlast   = out_l_reg;

    wire s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_depth_reg <= 2'd0;
            nat_depth_reg <= 2'd3;
            pack_reg      <= 1'b0;
            ccount_reg    <= 9'd256;
            cbytes_reg    <= 3'd1;
            budget_reg    <= 16'hFFFF;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PIXEL_DEPTH:  pix_depth_reg <= cfg_data[1:0];
                REG_NATIVE_DEPTH: nat_depth_reg <= cfg_data[1:0];
                REG_PACK_RUNS:    pack_reg      <= cfg_data[0];
                REG_COLOR_COUNT:  ccount_reg    <= cfg_data[8:0];
                REG_COLOR_BYTES:  cbytes_reg    <= cfg_data[2:0];
                REG_BYTE_BUDGET:  budget_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // current pixel from the top of the shifted word
    logic [7:0] pix;
    always_comb begin
        case (pix_depth_reg)
            2'd0:    pix = {7'd0, word_reg[31]};
            2'd1:    pix = {6'd0, word_reg[31:30]};
            2'd2:    pix = {4'd0, word_reg[31:28]};
            default: pix = word_reg[31:24];
        endcase
    end
    logic [31:0] word_shift;
    always_comb begin
        case (pix_depth_reg)
            2'd0:    word_shift = {word_reg[30:0], 1'b0};
            2'd1:    word_shift = {word_reg[29:0], 2'b0};
            2'd2:    word_shift = {word_reg[27:0], 4'b0};
            default: word_shift = {word_reg[23:0], 8'b0};
        endcase
    end

    logic [PIX_CNT_W-1:0] npix;
    always_comb begin
        npix = PIX_CNT_W'(WORD_BITS >> pix_depth_reg);
        if (s_tdata[32]) npix = npix >> 1;
    end

    // map lookup
    logic [6:0] map_rd;
    wire map_wr = s_fire && s_tuser && (32'(s_tdata[40:33]) < MAP_ENTRIES);
    wire map_rd_en = (state_reg == S_LOOK);
    pprle_map u_map (
        .aclk   (aclk),
        .wr_en  (map_wr),
        .wr_addr(s_tdata[33 +: MAP_AW]),
        .wr_data(s_tdata[47:41]),
        .rd_en  (map_rd_en),
        .rd_addr(pend_reg.color[MAP_AW-1:0]),
        .rd_data(map_rd)
    );

    // run_minus_one / 255 as ((x + 1) + ((x + 1) >> 8)) >> 8, exact over 16 bits
    logic [16:0] len_p1, len_div_sum;
    assign len_p1      = {1'b0, pend_reg.len} + 17'd1;
    assign len_div_sum = len_p1 + {8'd0, len_p1[16:8]};

    logic       oob_reg;
    logic [8:0] len_div_reg;
    always_ff @(posedge aclk) begin
        if (map_rd_en) begin
            oob_reg     <= 32'(pend_reg.color) >= MAP_ENTRIES;
            len_div_reg <= len_div_sum[16:8];
        end
    end

    // accounting for the run in S_ACCT
    logic [9:0]  nat_colors;
    logic        use_map, single;
    logic [7:0]  color, code;
    logic [16:0] nbytes;
    logic [17:0] bsum;
    logic [16:0] bytes_new;
    logic [15:0] singles_new;
    logic        ovf;
    always_comb begin
        nat_colors  = 10'd1 << (5'd1 << nat_depth_reg);
        use_map     = {1'b0, ccount_reg} < nat_colors;
        color       = use_map ? (oob_reg ? 8'd0 : {1'b0, map_rd}) : pend_reg.color;
        single      = pack_reg && (pend_reg.len == 16'd0);
        code        = single ? color : ((pack_reg ? PACKED_FLAG : 8'd0) | color);
        nbytes      = single ? 17'd1
                             : 17'(cbytes_reg) + 17'(len_div_reg) + 17'd1;
        bsum        = {1'b0, bytes_reg} + {1'b0, nbytes};
        bytes_new   = bsum[17] ? BYTES_MAX : bsum[16:0];
        singles_new = (single && singles_reg != 16'hFFFF) ? singles_reg + 16'd1
                                                          : singles_reg;
        ovf         = bytes_new > {1'b0, budget_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            aborted_reg   <= 1'b0;
            out_v_reg     <= 1'b0;
            first_reg     <= 1'b0;
            singles_reg   <= 16'd0;
            bytes_reg     <= 17'd0;
            run_color_reg <= 8'd0;
            run_len_reg   <= 16'd0;
        end else begin
            if (out_v_reg && m_tready && state_reg != S_ACCT) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire && !s_tuser) begin
                        word_reg  <= s_tdata[31:0];
                        left_reg  <= npix;
                        lastw_reg <= s_tlast;
                        first_reg <= !started_reg;
                        if (!started_reg) begin
                            started_reg <= 1'b1;
                            singles_reg <= 16'd0;
                            bytes_reg   <= 17'd0;
                            aborted_reg <= 1'b0;
                        end
                        state_reg <= (!started_reg || !aborted_reg) ? S_SCAN : S_END;
                    end
                end
                S_SCAN: begin
                    if (left_reg == '0) begin
                        state_reg <= S_END;
                    end else if (first_reg) begin
                        run_color_reg <= pix;
                        run_len_reg   <= 16'd0;
                        first_reg     <= 1'b0;
                        word_reg      <= word_shift;
                        left_reg      <= left_reg - 1'b1;
                    end else if (pix == run_color_reg) begin
                        if (run_len_reg != 16'hFFFF) run_len_reg <= run_len_reg + 16'd1;
                        word_reg <= word_shift;
                        left_reg <= left_reg - 1'b1;
                    end else begin
                        pend_reg      <= '{color: run_color_reg, len: run_len_reg, last: 1'b0};
                        run_color_reg <= pix;
                        run_len_reg   <= 16'd0;
                        word_reg      <= word_shift;
                        left_reg      <= left_reg - 1'b1;
                        state_reg     <= S_LOOK;
                    end
                end
                S_LOOK: state_reg <= S_ACCT;
                S_ACCT: begin
                    // wait for the output register to drain
                    if (!out_v_reg || m_tready) begin
                        out_v_reg   <= 1'b1;
                        out_d_reg   <= {6'd0, ovf, singles_new, single, pend_reg.len, code};
                        out_l_reg   <= pend_reg.last;
                        singles_reg <= singles_new;
                        bytes_reg   <= bytes_new;
                        if (pend_reg.last) begin
                            started_reg <= 1'b0;
                            state_reg   <= S_IDLE;
                        end else if (ovf) begin
                            aborted_reg <= 1'b1;
                            state_reg   <= S_END;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_END: begin
                    if (lastw_reg && !aborted_reg) begin
                        pend_reg  <= '{color: run_color_reg, len: run_len_reg, last: 1'b1};
                        state_reg <= S_LOOK;
                    end else begin
                        if (lastw_reg) started_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output request dropped or changed while stalled");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_tready)
        else $error("input accepted while busy");
    a_aborted_no_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        aborted_reg && state_reg == S_END |=> state_reg == S_IDLE)
        else $error("aborted tile kept scanning");
    a_look_then_acct: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOOK |=> state_reg == S_ACCT)
        else $error("map read not followed by accounting");
`endif
endmodule
